@@ design/ab2lp_pkg.sv @@
// Shared constants for the Annex B to length-prefixed converter.
// Used by annexb_to_length_prefixed_core and its port checker; no dependencies.
package ab2lp_pkg;

  // Default width of the output byte address space (capacity is 2**OFFSET_BITS)
  localparam int OFFSET_BITS_DEF = 24;

  // Bytes in a NAL length slot, and most zeros held back pending a start code
  localparam int PREFIX_BYTES = 4;
  localparam int MAX_HELD     = 3;

  // Fixed result field widths
  localparam int OUT_OFFSET_W = 24;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

endpackage

@@ design/annexb_to_length_prefixed_core.sv @@
// Annex B byte stream to length-prefixed NAL units, as addressed write requests.
// Depends on ab2lp_pkg (constants, result kinds).
//
//   channel | signals                                        | dir | per request
//   --------+------------------------------------------------+-----+---------------------
//   in      | in_valid, in_stall, data_byte, end_of_unit     | in  | one stream byte
//   out     | out_valid, out_stall, kind, offset, value,     | out | one write or end
//           | overflow, last_of_run                          |     | marker
//
// An input byte is parsed as it moves from the input register into the result
// register. A byte giving n results (n up to 6) occupies the result register until
// all n are taken by the one-result-per-cycle output port, which out_stall can hold;
// the input register takes one more byte meanwhile. Bytes giving no result still
// pass through without occupying the result register.
// Synchronous active-high reset clears the parser state and both registers.
module annexb_to_length_prefixed_core #(
  parameter int OFFSET_BITS = ab2lp_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                end_of_unit,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ab2lp_pkg::KIND_W-1:0]        kind,
  output logic [ab2lp_pkg::OUT_OFFSET_W-1:0]  offset,
  output logic [ab2lp_pkg::VALUE_W-1:0]       value,
  output logic                                overflow,
  output logic                                last_of_run
);

  localparam int AW = OFFSET_BITS + 1;  // address incl. one past capacity
  localparam int LW = OFFSET_BITS;      // NAL payload length
  localparam int OW = ab2lp_pkg::OUT_OFFSET_W;
  localparam int VW = ab2lp_pkg::VALUE_W;
  localparam logic [AW-1:0] CAP   = {1'b1, {OFFSET_BITS{1'b0}}};
  localparam logic [AW-1:0] PFX   = AW'(ab2lp_pkg::PREFIX_BYTES);
  localparam logic [1:0]    HMAX  = 2'(ab2lp_pkg::MAX_HELD);

  // Input register
  logic       ib_valid;
  logic [7:0] ib_data;
  logic       ib_eou;

  // Parser state
  logic          seen;
  logic [1:0]    held;
  logic [AW-1:0] prefix;
  logic [LW-1:0] nal;
  logic          ovf;

  // Result register: a payload run, an optional length word, an optional end marker
  logic [2:0]    pay_left;
  logic [OW-1:0] pay_addr;
  logic [7:0]    pay_last;
  logic          has_len;
  logic [OW-1:0] len_off;
  logic [VW-1:0] len_val;
  logic          has_end;
  logic [VW-1:0] end_val;
  logic          end_ovf;

  logic       job_valid;
  logic [2:0] job_count;
  logic       take;
  logic       load;

  // Handshake and hand-over
  assign job_valid = (pay_left != 3'd0) | has_len | has_end;
  assign job_count = pay_left + {2'b00, has_len} + {2'b00, has_end};
  assign take      = job_valid & ~out_stall;
  assign load      = ib_valid & (~job_valid | (take & (job_count == 3'd1)));
  assign in_stall  = ib_valid & ~load;

  // Parse one byte: step on the byte, then end-of-unit flush
  logic          seen_next;
  logic [1:0]    held_next;
  logic [AW-1:0] prefix_next;
  logic [LW-1:0] nal_s;
  logic [LW-1:0] nal_next;
  logic          ovf_next;
  logic [2:0]    want1;
  logic [2:0]    want2;
  logic [2:0]    want;
  logic          want_byte;
  logic          l1;
  logic [AW-1:0] addr0;
  logic [AW:0]   addr_end;
  logic          over;
  logic [AW-1:0] room;
  logic [2:0]    n_pay;
  logic          l2;
  logic [AW-1:0] total;
  logic [AW+OW-1:0] prefix_ext;
  logic [AW+OW-1:0] old_prefix_ext;
  logic [AW+OW-1:0] addr_ext;
  logic [LW+VW-1:0] nal_s_ext;
  logic [LW+VW-1:0] nal_ext;
  logic [AW+VW-1:0] total_ext;

  always_comb begin
    seen_next   = seen;
    held_next   = held;
    prefix_next = prefix;
    nal_s       = nal;
    want1       = 3'd0;
    want_byte   = 1'b0;
    l1          = 1'b0;
    if (!ovf) begin
      if (ib_data == 8'h00) begin
        // zero: hold it, or release the oldest held zero once three are held
        if (held == HMAX) begin
          want1 = {2'b00, seen};
        end else begin
          held_next = held + 2'd1;
        end
      end else if (ib_data == 8'h01 && held >= 2'd2) begin
        // start code: close a non-empty NAL unit
        if (seen && nal != '0) begin
          l1          = 1'b1;
          prefix_next = prefix + PFX + {1'b0, nal};
          nal_s       = '0;
        end
        seen_next = 1'b1;
        held_next = 2'd0;
      end else begin
        // ordinary byte: held zeros were payload after all
        want1     = seen ? ({1'b0, held} + 3'd1) : 3'd0;
        want_byte = seen;
        held_next = 2'd0;
      end
    end
  end

  // Zeros still held at end of unit become payload
  assign want2 = (!ovf && ib_eou && seen_next) ? {1'b0, held_next} : 3'd0;
  assign want  = want1 + want2;

  // Capacity check over the whole payload run; a run only exists when no slot
  // was closed by this byte, so it starts behind the current slot
  assign addr0    = prefix + PFX + {1'b0, nal};
  assign addr_end = {1'b0, addr0} + {{(AW-2){1'b0}}, want};
  assign over     = (want != 3'd0) && (addr_end > {1'b0, CAP});
  assign room     = CAP - addr0;
  assign n_pay    = over ? ((addr0 >= CAP) ? 3'd0 : room[2:0]) : want;
  assign ovf_next = ovf | over;
  assign nal_next = nal_s + {{(LW-3){1'b0}}, n_pay};

  // Closing length word and total size
  assign l2    = ib_eou & ~ovf_next & (nal_next != '0);
  assign total = (nal_next != '0) ? (addr0 + {{(AW-3){1'b0}}, n_pay}) : prefix_next;

  assign prefix_ext     = {{OW{1'b0}}, prefix_next};
  assign old_prefix_ext = {{OW{1'b0}}, prefix};
  assign addr_ext       = {{OW{1'b0}}, addr0};
  assign nal_s_ext      = {{VW{1'b0}}, nal};
  assign nal_ext        = {{VW{1'b0}}, nal_next};
  assign total_ext      = {{VW{1'b0}}, total};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (!in_stall) begin
      ib_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ib_data <= data_byte;
      ib_eou  <= end_of_unit;
    end
  end

  // Parser state, back to reset after each access unit
  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= 1'b0;
      held   <= 2'd0;
      prefix <= '0;
      nal    <= '0;
      ovf    <= 1'b0;
    end else if (load) begin
      if (ib_eou) begin
        seen   <= 1'b0;
        held   <= 2'd0;
        prefix <= '0;
        nal    <= '0;
        ovf    <= 1'b0;
      end else begin
        seen   <= seen_next;
        held   <= held_next;
        prefix <= prefix_next;
        nal    <= nal_next;
        ovf    <= ovf_next;
      end
    end
  end

  // Result register control: load a new run, or retire one result per request
  always_ff @(posedge clk) begin
    if (rst) begin
      pay_left <= 3'd0;
      has_len  <= 1'b0;
      has_end  <= 1'b0;
    end else if (load) begin
      pay_left <= n_pay;
      has_len  <= l1 | l2;
      has_end  <= ib_eou;
    end else if (take) begin
      if (pay_left != 3'd0) begin
        pay_left <= pay_left - 3'd1;
      end else if (has_len) begin
        has_len <= 1'b0;
      end else begin
        has_end <= 1'b0;
      end
    end
  end

  // Result register payload; a slot closed by a start code sits at the old prefix
  always_ff @(posedge clk) begin
    if (load) begin
      pay_addr <= addr_ext[OW-1:0];
      pay_last <= (want_byte && !over) ? ib_data : 8'h00;
      len_off  <= l1 ? old_prefix_ext[OW-1:0] : prefix_ext[OW-1:0];
      len_val  <= l1 ? nal_s_ext[VW-1:0] : nal_ext[VW-1:0];
      end_val  <= ovf_next ? '0 : total_ext[VW-1:0];
      end_ovf  <= ovf_next;
    end else if (take && pay_left != 3'd0) begin
      pay_addr <= pay_addr + OW'(1);
    end
  end

  // Present the oldest outstanding result
  always_comb begin
    kind     = ab2lp_pkg::KIND_END;
    offset   = '0;
    value    = end_val;
    overflow = end_ovf;
    if (pay_left != 3'd0) begin
      kind     = ab2lp_pkg::KIND_PAYLOAD;
      offset   = pay_addr;
      value    = (pay_left == 3'd1) ? {{(VW-8){1'b0}}, pay_last} : '0;
      overflow = 1'b0;
    end else if (has_len) begin
      kind     = ab2lp_pkg::KIND_LENGTH;
      offset   = len_off;
      value    = len_val;
      overflow = 1'b0;
    end
  end

  assign out_valid   = job_valid;
  assign last_of_run = (job_count == 3'd1);

endmodule

@@ design/ab2lp_checker.sv @@
// Port-level checker for annexb_to_length_prefixed_core, bound into that module.
// Depends on ab2lp_pkg (result kinds).
module ab2lp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ab2lp_pkg::KIND_W-1:0]        kind,
  input logic [ab2lp_pkg::OUT_OFFSET_W-1:0]  offset,
  input logic [ab2lp_pkg::VALUE_W-1:0]       value,
  input logic                                overflow,
  input logic                                last_of_run
);

  // A stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(offset)
      && $stable(value) && $stable(overflow) && $stable(last_of_run))
    else $error("result request changed while stalled");

  // Only the three defined kinds appear
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == ab2lp_pkg::KIND_PAYLOAD || kind == ab2lp_pkg::KIND_LENGTH
      || kind == ab2lp_pkg::KIND_END))
    else $error("undefined result kind");

  // The end marker is always the final result of its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ab2lp_pkg::KIND_END |-> last_of_run)
    else $error("end marker not last of run");

  // Overflow is only flagged on the end marker
  a_ovf_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> kind == ab2lp_pkg::KIND_END)
    else $error("overflow on a write request");

  // Input is never stalled unless a result is waiting to go out
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind annexb_to_length_prefixed_core ab2lp_checker u_ab2lp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .offset      (offset),
  .value       (value),
  .overflow    (overflow),
  .last_of_run (last_of_run)
);

@@ test/tb_top.sv @@
// Testbench for annexb_to_length_prefixed_core: directed table, then random units.
// Depends on ab2lp_pkg and the core; expected writes come from a parser model held here.
`timescale 1ns / 1ps

module tb_top;
  import ab2lp_pkg::*;

  // Address space width used by this testbench
  localparam int          ADDR_BITS    = 16;
  localparam logic [32:0] CAPACITY     = 33'd1 << ADDR_BITS;
  localparam int          RANDOM_ITEMS = 430;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          RUN_LIMIT    = 2000000;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [OUT_OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]      value;
    logic                    ovf;
    logic                    last;
  } nal_write_t;

  typedef struct packed {
    logic [7:0]              b;
    logic                    eou;
    logic                    typed;
    logic [KIND_W-1:0]       kind;
    logic [OUT_OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]      value;
    logic                    ovf;
  } stim_row_t;

  // Directed requests; typed rows carry the single write they must give
  localparam stim_row_t DIR_ROWS [0:27] = '{
    '{8'h00, 1'b1, 1'b1, KIND_END,     24'd0, 32'd0,     1'b0}, // lone zero ends unit
    '{8'h42, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0}, // junk before start code
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0}, // dropped, no start yet
    '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h65, 1'b0, 1'b1, KIND_PAYLOAD, 24'd4, 32'h65,    1'b0},
    '{8'hFF, 1'b0, 1'b1, KIND_PAYLOAD, 24'd5, 32'hFF,    1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h01, 1'b0, 1'b1, KIND_LENGTH,  24'd0, 32'd2,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0}, // fourth zero is payload
    '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0}, // releases held zeros
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0}, // empty NAL unit
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0},
    '{8'h00, 1'b1, 1'b0, KIND_PAYLOAD, 24'd0, 32'd0,     1'b0}  // zeros flushed at end
  };

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              data_byte;
  logic                    end_of_unit;
  logic                    out_valid;
  logic                    out_stall;
  logic [KIND_W-1:0]       kind;
  logic [OUT_OFFSET_W-1:0] offset;
  logic [VALUE_W-1:0]      value;
  logic                    overflow;
  logic                    last_of_run;

  // Parser model state
  logic        prs_seen;
  logic [1:0]  prs_held;
  logic [32:0] prs_slot;
  logic [32:0] prs_nal_len;
  logic        prs_full;

  nal_write_t  byte_writes[$];
  nal_write_t  pending_writes[$];
  logic [7:0]  unit_bytes[$];
  nal_write_t  got;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  logic        idle_on     = 1'b1;
  logic        hold_req    = 1'b0;

  annexb_to_length_prefixed_core #(.OFFSET_BITS(ADDR_BITS)) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_unit (end_of_unit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .offset      (offset),
    .value       (value),
    .overflow    (overflow),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_write(logic [KIND_W-1:0] k, logic [32:0] off,
                                    logic [32:0] val, logic ovf);
    nal_write_t w;
    w.kind   = k;
    w.offset = off[OUT_OFFSET_W-1:0];
    w.value  = val[VALUE_W-1:0];
    w.ovf    = ovf;
    w.last   = 1'b0;
    byte_writes.insert(byte_writes.size(), w);
  endfunction

  // Payload write behind the current length slot, unless capacity is gone
  function automatic void put_payload(logic [7:0] b);
    logic [32:0] addr;
    if (prs_full) return;
    addr = prs_slot + PREFIX_BYTES + prs_nal_len;
    if (addr >= CAPACITY) begin
      prs_full = 1'b1;
      return;
    end
    add_write(KIND_PAYLOAD, addr, {25'd0, b}, 1'b0);
    prs_nal_len = prs_nal_len + 1;
  endfunction

  function automatic void flush_held();
    int i;
    if (prs_seen)
      for (i = 0; i < prs_held; i++) put_payload(8'h00);
    prs_held = 2'd0;
  endfunction

  function automatic void clear_parser();
    prs_seen    = 1'b0;
    prs_held    = 2'd0;
    prs_slot    = '0;
    prs_nal_len = '0;
    prs_full    = 1'b0;
  endfunction

  // Writes caused by one stream byte, left in byte_writes
  function automatic void predict_writes(logic [7:0] b, logic eou);
    logic [32:0] total;
    nal_write_t  w;
    byte_writes.delete();
    if (!prs_full) begin
      if (b == 8'h00) begin
        if (prs_held >= MAX_HELD) begin
          if (prs_seen) put_payload(8'h00);
        end else begin
          prs_held = prs_held + 2'd1;
        end
      end else if (b == 8'h01 && prs_held >= 2) begin
        if (prs_seen && prs_nal_len != 0) begin
          add_write(KIND_LENGTH, prs_slot, prs_nal_len, 1'b0);
          prs_slot    = prs_slot + PREFIX_BYTES + prs_nal_len;
          prs_nal_len = '0;
        end
        prs_seen = 1'b1;
        prs_held = 2'd0;
      end else begin
        flush_held();
        if (prs_seen) put_payload(b);
      end
    end
    if (eou) begin
      total = '0;
      if (!prs_full) flush_held();
      if (!prs_full) begin
        total = prs_slot;
        if (prs_nal_len != 0) begin
          add_write(KIND_LENGTH, prs_slot, prs_nal_len, 1'b0);
          total = total + PREFIX_BYTES + prs_nal_len;
        end
      end
      add_write(KIND_END, '0, prs_full ? 33'd0 : total, prs_full);
      clear_parser();
    end
    if (byte_writes.size() != 0) begin
      w      = byte_writes[byte_writes.size() - 1];
      w.last = 1'b1;
      byte_writes[byte_writes.size() - 1] = w;
    end
  endfunction

  // Offer one request and hold it until it is taken
  task automatic drive_req(logic [7:0] b, logic eou);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_byte   <= b;
    end_of_unit <= eou;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(logic [7:0] b, logic eou);
    predict_writes(b, eou);
    pending_writes = {pending_writes, byte_writes};
    drive_req(b, eou);
  endtask

  // Payload-like byte: zeros and 01 are common so start codes form by chance
  function automatic logic [7:0] rand_content();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h00;
    if (r == 3) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  // One access unit: mostly well formed, sometimes with junk or cut short
  function automatic void fill_unit();
    int unsigned n_nal;
    int unsigned zeros;
    int unsigned len;
    int unsigned cut;
    unit_bytes.delete();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) unit_bytes.insert(unit_bytes.size(), rand_content());
    n_nal = $urandom_range(0, 4);
    repeat (n_nal) begin
      zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
      repeat (zeros) unit_bytes.insert(unit_bytes.size(), 8'h00);
      unit_bytes.insert(unit_bytes.size(), 8'h01);
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      repeat (len) unit_bytes.insert(unit_bytes.size(), rand_content());
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) unit_bytes.insert(unit_bytes.size(), 8'h00);
    if (unit_bytes.size() == 0)
      unit_bytes.insert(unit_bytes.size(), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0 && unit_bytes.size() > 1) begin
      cut = $urandom_range(1, unit_bytes.size() - 1);
      while (unit_bytes.size() > cut) void'(unit_bytes.pop_back());
    end
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int unsigned n;
    logic        s;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        s        = 1'b1;
        n        = HOLD_CYCLES;
      end else begin
        n = pick_gap();
        s = (n != 0);
        if (!s) n = $urandom_range(1, 6);
      end
      out_stall <= s;
      repeat (n) @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%0s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
      err_count++;
    end
  endfunction

  // Compare each accepted write with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: kind %0d offset 0x%0h value 0x%0h", kind, offset, value);
        err_count++;
      end else begin
        got = pending_writes.pop_front();
        check_field("kind", 32'(got.kind), 32'(kind));
        check_field("offset", 32'(got.offset), 32'(offset));
        check_field("value", got.value, value);
        check_field("overflow", 32'(got.ovf), 32'(overflow));
        check_field("last_of_run", 32'(got.last), 32'(last_of_run));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    nal_write_t  want;
    int unsigned sent;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    data_byte   <= 8'h00;
    end_of_unit <= 1'b0;
    clear_parser();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (DIR_ROWS[i]) begin
      predict_writes(DIR_ROWS[i].b, DIR_ROWS[i].eou);
      if (DIR_ROWS[i].typed) begin
        want = '{DIR_ROWS[i].kind, DIR_ROWS[i].offset, DIR_ROWS[i].value,
                 DIR_ROWS[i].ovf, 1'b1};
        pending_writes.insert(pending_writes.size(), want);
      end else begin
        pending_writes = {pending_writes, byte_writes};
      end
      drive_req(DIR_ROWS[i].b, DIR_ROWS[i].eou);
    end

    // Random units; the first one runs into a long receiver hold-off
    sent     = 0;
    hold_req = 1'b1;
    idle_on  = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      fill_unit();
      foreach (unit_bytes[i]) begin
        issue(unit_bytes[i], i == unit_bytes.size() - 1);
        sent++;
      end
      idle_on = ($urandom_range(0, 3) != 0);
    end
    idle_on  = 1'b1;
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
